FILE: hw/rtl/gas_pkg.sv
package gas_pkg;

    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int FIELD_ID_W  = 16;
    localparam int FIELD_WT_W  = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_ADD_VERTEX   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_VERTEX   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE_EDGE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_EDGE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY_EDGE   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY_VERTEX = 3'd6;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_EXISTS    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_VERTEX = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NO_EDGE   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_CLEAR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load_in;
        logic look;
        logic exec;
        logic clear;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_clear;
        logic clear_last;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: hw/rtl/gas_ram.sv
module gas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gas_ctrl.sv
module gas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  gas_pkg::t_dp_sts  i_sts,
    output gas_pkg::t_ctl_cmd o_ctl
);
    import gas_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK:  n_state = S_EXEC;
            S_EXEC: begin
                n_state = i_sts.need_clear ? S_CLEAR : S_RESP;
            end
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_ctl.load_in = i_s_tvalid;
            end
            S_LOOK:  o_ctl.look  = 1'b1;
            S_EXEC:  o_ctl.exec  = 1'b1;
            S_CLEAR: o_ctl.clear = 1'b1;
            S_RESP:  o_ctl.load_out = !i_sts.out_busy;
            default: o_ctl = '0;
        endcase
    end

endmodule

FILE: hw/rtl/gas_dp.sv
module gas_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int ID_BITS      = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gas_pkg::t_ctl_cmd                   i_ctl,
    output gas_pkg::t_dp_sts                    o_sts,
    input  logic [gas_pkg::CMD_W-1:0]           i_cmd,
    input  logic [gas_pkg::FIELD_ID_W-1:0]      i_vertex_id,
    input  logic [gas_pkg::FIELD_ID_W-1:0]      i_other_id,
    input  logic [gas_pkg::FIELD_WT_W-1:0]      i_weight,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [gas_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_found,
    output logic [gas_pkg::FIELD_WT_W-1:0]      o_weight_out
);
    import gas_pkg::*;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int EW   = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int ID_W = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
    localparam int WT_W = (WEIGHT_BITS < FIELD_WT_W) ? WEIGHT_BITS : FIELD_WT_W;

    logic [CMD_W-1:0]        r_cmd;
    logic [ID_W-1:0]         r_a;
    logic [ID_W-1:0]         r_b;
    logic [WT_W-1:0]         r_w;
    logic [ID_W-1:0]         r_ids [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vvalid;
    logic [MAX_VERTICES-1:0] r_ev [MAX_VERTICES];
    logic [VW-1:0]           r_sa;
    logic [VW-1:0]           r_sb;
    logic [VW-1:0]           r_free;
    logic                    r_sa_hit;
    logic                    r_sb_hit;
    logic                    r_free_hit;
    logic [VW-1:0]           r_k;
    logic [STATUS_W-1:0]     r_res_status;
    logic                    r_res_found;
    logic [FIELD_WT_W-1:0]   r_res_wout;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic                    r_out_found;
    logic [FIELD_WT_W-1:0]   r_out_wout;

    logic [VW-1:0]         n_sa;
    logic [VW-1:0]         n_sb;
    logic [VW-1:0]         n_free;
    logic                  n_sa_hit;
    logic                  n_sb_hit;
    logic                  n_free_hit;
    logic [EW-1:0]         n_raddr;
    logic [EW-1:0]         w_waddr;
    logic [WT_W-1:0]       w_rdata;
    logic                  w_have_edge;
    logic [STATUS_W-1:0]   n_status;
    logic                  n_found;
    logic [FIELD_WT_W-1:0] n_wout;
    logic                  w_vtx_set;
    logic                  w_vtx_clr;
    logic                  w_edge_set;
    logic                  w_edge_clr;
    logic                  w_ram_we;

    // parallel id match, lowest slot wins
    always_comb begin
        n_sa       = '0;
        n_sb       = '0;
        n_free     = '0;
        n_sa_hit   = 1'b0;
        n_sb_hit   = 1'b0;
        n_free_hit = 1'b0;
        for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (r_vvalid[k] && (r_ids[k] == r_a)) begin
                n_sa     = VW'(k);
                n_sa_hit = 1'b1;
            end
            if (r_vvalid[k] && (r_ids[k] == r_b)) begin
                n_sb     = VW'(k);
                n_sb_hit = 1'b1;
            end
            if (!r_vvalid[k]) begin
                n_free     = VW'(k);
                n_free_hit = 1'b1;
            end
        end
    end

    assign n_raddr = EW'(EW'(n_sa) * EW'(MAX_VERTICES) + EW'(n_sb));
    assign w_waddr = EW'(EW'(r_sa) * EW'(MAX_VERTICES) + EW'(r_sb));

    assign w_have_edge = r_sa_hit && r_sb_hit && r_ev[r_sa][r_sb];

    always_comb begin
        n_status   = STS_OK;
        n_found    = 1'b0;
        n_wout     = '0;
        w_vtx_set  = 1'b0;
        w_vtx_clr  = 1'b0;
        w_edge_set = 1'b0;
        w_edge_clr = 1'b0;
        w_ram_we   = 1'b0;
        unique case (r_cmd)
            CMD_ADD_VERTEX: begin
                if (r_sa_hit) begin
                    n_status = STS_EXISTS;
                end else if (!r_free_hit) begin
                    n_status = STS_FULL;
                end else begin
                    w_vtx_set = 1'b1;
                end
            end
            CMD_DEL_VERTEX: begin
                if (!r_sa_hit) begin
                    n_status = STS_NO_VERTEX;
                end else begin
                    w_vtx_clr = 1'b1;
                end
            end
            CMD_ADD_EDGE: begin
                if (!(r_sa_hit && r_sb_hit)) begin
                    n_status = STS_NO_VERTEX;
                end else if (w_have_edge) begin
                    n_status = STS_EXISTS;
                end else begin
                    w_edge_set = 1'b1;
                    w_ram_we   = 1'b1;
                end
            end
            CMD_UPDATE_EDGE: begin
                if (!w_have_edge) begin
                    n_status = STS_NO_EDGE;
                end else begin
                    w_ram_we = 1'b1;
                end
            end
            CMD_DEL_EDGE: begin
                if (!w_have_edge) begin
                    n_status = STS_NO_EDGE;
                end else begin
                    w_edge_clr = 1'b1;
                end
            end
            CMD_QUERY_EDGE: begin
                if (!w_have_edge) begin
                    n_status = STS_NO_EDGE;
                end else begin
                    n_found = 1'b1;
                    n_wout  = FIELD_WT_W'(w_rdata);
                end
            end
            CMD_QUERY_VERTEX: begin
                if (!r_sa_hit) begin
                    n_status = STS_NO_VERTEX;
                end else begin
                    n_found = 1'b1;
                end
            end
            default: n_status = STS_OK;
        endcase
    end

    gas_ram #(
        .WIDTH (WT_W),
        .DEPTH (MAX_VERTICES * MAX_VERTICES)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (i_ctl.exec && w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_w),
        .i_re    (i_ctl.look),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd <= i_cmd;
            r_a   <= i_vertex_id[ID_W-1:0];
            r_b   <= i_other_id[ID_W-1:0];
            r_w   <= i_weight[WT_W-1:0];
        end
        if (i_ctl.look) begin
            r_sa       <= n_sa;
            r_sb       <= n_sb;
            r_free     <= n_free;
            r_sa_hit   <= n_sa_hit;
            r_sb_hit   <= n_sb_hit;
            r_free_hit <= n_free_hit;
        end
        if (i_ctl.exec) begin
            r_res_status <= n_status;
            r_res_found  <= n_found;
            r_res_wout   <= n_wout;
            if (w_vtx_set) begin
                r_ids[r_free] <= r_a;
            end
        end
        if (i_ctl.load_out) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_wout   <= r_res_wout;
        end
    end

    // valid bits, row and column walk and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvalid    <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_VERTICES; k++) begin
                r_ev[k] <= '0;
            end
        end else begin
            if (i_ctl.exec) begin
                r_k <= '0;
                if (w_vtx_set) begin
                    r_vvalid[r_free] <= 1'b1;
                end
                if (w_vtx_clr) begin
                    r_vvalid[r_sa] <= 1'b0;
                end
                if (w_edge_set) begin
                    r_ev[r_sa][r_sb] <= 1'b1;
                end
                if (w_edge_clr) begin
                    r_ev[r_sa][r_sb] <= 1'b0;
                end
            end
            if (i_ctl.clear) begin
                r_k              <= r_k + 1'b1;
                r_ev[r_sa][r_k]  <= 1'b0;
                r_ev[r_k][r_sa]  <= 1'b0;
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_clear = (r_cmd == CMD_DEL_VERTEX) && r_sa_hit;
    assign o_sts.clear_last = (r_k == VW'(MAX_VERTICES - 1));
    assign o_sts.out_busy   = r_out_valid && !i_m_tready;

    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_out_status;
    assign o_found      = r_out_found;
    assign o_weight_out = r_out_wout;

endmodule

FILE: hw/rtl/graph_adjacency_store_top.sv
// Directed weighted graph store: a table of MAX_VERTICES vertex ids and a
// MAX_VERTICES x MAX_VERTICES matrix of edge weights. Each request (command
// on s_tuser, ids and weight on s_tdata) gives exactly one response with a
// status on m_tuser and found/weight on m_tdata. Requests are handled one at
// a time: after a request is accepted the ids are looked up, the command is
// executed and, for a vertex delete that succeeds, the vertex's row and
// column are walked one slot per cycle; the response is then loaded into the
// output register once that is free, and only then is the next request taken.
// A new request is taken while the previous response waits in the output
// register. Ids and weights are kept in their low ID_BITS and WEIGHT_BITS
// bits; a queried weight returns zero-extended from those bits. All vertex
// and edge valid bits are cleared by reset, so the block is usable in the
// cycle after reset is released.
module graph_adjacency_store_top #(
    parameter int MAX_VERTICES = 16,
    parameter int ID_BITS      = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [15:0] vertex_id, [31:16] other_id, [47:32] weight
    input  logic [gas_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [2:0] command
    input  logic [gas_pkg::CMD_W-1:0]          i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] found, [16:1] weight_out, [23:17] zero
    output logic [gas_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [2:0] status
    output logic [gas_pkg::STATUS_W-1:0]       o_m_tuser
);
    import gas_pkg::*;

    t_ctl_cmd              w_ctl;
    t_dp_sts               w_sts;
    logic                  w_found;
    logic [FIELD_WT_W-1:0] w_wout;

    gas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    gas_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .ID_BITS      (ID_BITS),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cmd        (i_s_tuser),
        .i_vertex_id  (i_s_tdata[FIELD_ID_W-1:0]),
        .i_other_id   (i_s_tdata[2*FIELD_ID_W-1:FIELD_ID_W]),
        .i_weight     (i_s_tdata[2*FIELD_ID_W+FIELD_WT_W-1:2*FIELD_ID_W]),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_status     (o_m_tuser),
        .o_found      (w_found),
        .o_weight_out (w_wout)
    );

    assign o_m_tdata = OUT_TDATA_W'({w_wout, w_found});

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctl.load_in, w_ctl.look, w_ctl.exec, w_ctl.clear, w_ctl.load_out}))
        else $error("controller issued more than one step at once");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("response loaded over one not yet taken");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (!o_s_tready && w_ctl.look))
        else $error("request not followed by lookup");

endmodule

FILE: tb/graph_adjacency_store_top_tb.sv
module graph_adjacency_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gas_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_REQUESTS = 500;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  found;
        logic [FIELD_WT_W-1:0] weight;
    } t_response;

    class graph_mirror;
        localparam int NV = 16;

        logic [FIELD_ID_W-1:0] ids [NV];
        bit                    id_live [NV];
        logic [FIELD_WT_W-1:0] weights [NV*NV];
        bit                    edge_live [NV*NV];
        t_response             pending_responses [$];
        int                    errors;

        function new();
            foreach (ids[k]) begin
                ids[k]     = '0;
                id_live[k] = 1'b0;
            end
            foreach (weights[k]) begin
                weights[k]   = '0;
                edge_live[k] = 1'b0;
            end
            errors = 0;
        endfunction

        function int slot_of(logic [FIELD_ID_W-1:0] id);
            for (int k = 0; k < NV; k++) begin
                if (id_live[k] && ids[k] == id) return k;
            end
            return -1;
        endfunction

        function int free_slot();
            for (int k = 0; k < NV; k++) begin
                if (!id_live[k]) return k;
            end
            return -1;
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [FIELD_ID_W-1:0] src,
                                   logic [FIELD_ID_W-1:0] dst, logic [FIELD_WT_W-1:0] w);
            int        sa;
            int        sd;
            int        e;
            int        k;
            bit        have_edge;
            t_response r;
            sa = slot_of(src);
            sd = slot_of(dst);
            e = (sa >= 0 && sd >= 0) ? sa * NV + sd : -1;
            have_edge = 1'b0;
            if (e >= 0) have_edge = edge_live[e];
            r = '0;
            r.status = STS_OK;
            case (cmd)
                CMD_ADD_VERTEX: begin
                    if (sa >= 0) begin
                        r.status = STS_EXISTS;
                    end else begin
                        k = free_slot();
                        if (k < 0) begin
                            r.status = STS_FULL;
                        end else begin
                            ids[k]     = src;
                            id_live[k] = 1'b1;
                        end
                    end
                end
                CMD_DEL_VERTEX: begin
                    if (sa < 0) begin
                        r.status = STS_NO_VERTEX;
                    end else begin
                        for (k = 0; k < NV; k++) begin
                            edge_live[sa*NV + k] = 1'b0;
                            edge_live[k*NV + sa] = 1'b0;
                        end
                        id_live[sa] = 1'b0;
                    end
                end
                CMD_ADD_EDGE: begin
                    if (e < 0) begin
                        r.status = STS_NO_VERTEX;
                    end else if (have_edge) begin
                        r.status = STS_EXISTS;
                    end else begin
                        weights[e]   = w;
                        edge_live[e] = 1'b1;
                    end
                end
                CMD_UPDATE_EDGE: begin
                    if (!have_edge) r.status = STS_NO_EDGE;
                    else weights[e] = w;
                end
                CMD_DEL_EDGE: begin
                    if (!have_edge) r.status = STS_NO_EDGE;
                    else edge_live[e] = 1'b0;
                end
                CMD_QUERY_EDGE: begin
                    if (!have_edge) begin
                        r.status = STS_NO_EDGE;
                    end else begin
                        r.found  = 1'b1;
                        r.weight = weights[e];
                    end
                end
                CMD_QUERY_VERTEX: begin
                    if (sa < 0) r.status = STS_NO_VERTEX;
                    else r.found = 1'b1;
                end
                default: begin
                end
            endcase
            pending_responses.insert(pending_responses.size(), r);
        endfunction

        task flag_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(logic [STATUS_W-1:0] status, logic found,
                            logic [FIELD_WT_W-1:0] weight);
            t_response want;
            if (pending_responses.size() == 0) begin
                flag_mismatch("response with no request outstanding");
            end else begin
                want = pending_responses.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (found !== want.found)
                    flag_mismatch($sformatf("found %0b, want %0b", found, want.found));
                if (weight !== want.weight)
                    flag_mismatch($sformatf("weight %h, want %h", weight, want.weight));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // [15:0] vertex_id, [31:16] other_id, [47:32] weight
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    // [2:0] command
    logic [CMD_W-1:0]       i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // [0] found, [16:1] weight_out, [23:17] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // [2:0] status
    logic [STATUS_W-1:0]    o_m_tuser;

    graph_mirror           mirror;
    logic [FIELD_ID_W-1:0] id_pool [POOL_SIZE];
    bit                    no_idle;
    bit                    hold_off_request;

    graph_adjacency_store_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                mirror.note_request(i_s_tuser, i_s_tdata[15:0], i_s_tdata[31:16],
                                    i_s_tdata[47:32]);
            if (o_m_tvalid && i_m_tready)
                mirror.check_response(o_m_tuser, o_m_tdata[0], o_m_tdata[16:1]);
        end
    end

    task send_request(input logic [CMD_W-1:0] cmd, input logic [FIELD_ID_W-1:0] src,
                      input logic [FIELD_ID_W-1:0] dst, input logic [FIELD_WT_W-1:0] w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {w, dst, src};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task random_request();
        int                    pick;
        logic [CMD_W-1:0]      cmd;
        logic [FIELD_ID_W-1:0] src;
        logic [FIELD_ID_W-1:0] dst;
        logic [FIELD_WT_W-1:0] w;
        pick = $urandom_range(0, 99);
        src  = id_pool[$urandom_range(0, POOL_SIZE-1)];
        dst  = id_pool[$urandom_range(0, POOL_SIZE-1)];
        w    = FIELD_WT_W'($urandom);
        if (pick < 20)      cmd = CMD_ADD_VERTEX;
        else if (pick < 30) cmd = CMD_DEL_VERTEX;
        else if (pick < 52) cmd = CMD_ADD_EDGE;
        else if (pick < 64) cmd = CMD_UPDATE_EDGE;
        else if (pick < 72) cmd = CMD_DEL_EDGE;
        else if (pick < 86) cmd = CMD_QUERY_EDGE;
        else if (pick < 93) cmd = CMD_QUERY_VERTEX;
        else if (pick < 96) cmd = CMD_UNUSED;
        else begin
            // unknown ids, mostly misses
            cmd = CMD_W'($urandom_range(CMD_ADD_VERTEX, CMD_QUERY_VERTEX));
            src = FIELD_ID_W'($urandom);
            dst = FIELD_ID_W'($urandom);
        end
        send_request(cmd, src, dst, w);
    endtask

    task wait_drained();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (mirror.pending() != 0);
    endtask

    // receiver side
    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = 300;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        #1_000_000;
        $display("graph_adjacency_store_top_tb: errors");
        $finish;
    end

    initial begin
        mirror           = new();
        no_idle          = 1'b0;
        hold_off_request = 1'b0;
        i_rst_n          = 1'b0;
        i_s_tvalid       = 1'b0;
        i_s_tdata        = '0;
        i_s_tuser        = CMD_ADD_VERTEX;

        // fixed ids double as the fill set; a few random ones besides
        id_pool[0] = 16'h0000;
        for (int k = 1; k < 16; k++) id_pool[k] = 16'(k * 16'h1111);
        id_pool[16] = 16'h8001;
        for (int k = 17; k < POOL_SIZE; k++) id_pool[k] = FIELD_ID_W'($urandom);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(CMD_QUERY_VERTEX, 16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_ADD_VERTEX,   16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_ADD_VERTEX,   16'hFFFF, 16'h0000, 16'h0000);
        send_request(CMD_ADD_VERTEX,   16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(CMD_ADD_EDGE,     16'h0000, 16'hFFFF, 16'h8000);
        send_request(CMD_ADD_EDGE,     16'h0000, 16'hFFFF, 16'h0001);
        send_request(CMD_ADD_EDGE,     16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_request(CMD_ADD_EDGE,     16'h0000, 16'h5A5A, 16'h1234);
        send_request(CMD_UPDATE_EDGE,  16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(CMD_QUERY_EDGE,   16'h0000, 16'hFFFF, 16'h0000);
        send_request(CMD_DEL_EDGE,     16'hFFFF, 16'h0000, 16'h0000);
        send_request(CMD_UPDATE_EDGE,  16'h0000, 16'h5A5A, 16'hA5A5);
        send_request(CMD_UNUSED,       16'hFFFF, 16'hFFFF, 16'hFFFF);
        // vertex delete must drop its row and column
        send_request(CMD_DEL_VERTEX,   16'hFFFF, 16'h0000, 16'h0000);
        send_request(CMD_QUERY_EDGE,   16'h0000, 16'hFFFF, 16'h0000);
        send_request(CMD_DEL_VERTEX,   16'hFFFF, 16'h0000, 16'h0000);
        for (int k = 1; k < 16; k++)
            send_request(CMD_ADD_VERTEX, id_pool[k], 16'h0000, 16'h0000);
        send_request(CMD_ADD_VERTEX,   16'h8001, 16'h0000, 16'h0000);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 150) begin
                hold_off_request = 1'b1;
                no_idle          = 1'b1;
            end
            if (n == 200) no_idle = 1'b0;
            if (n == 300) wait_drained();
            if (n == 350) no_idle = 1'b1;
            if (n == 400) no_idle = 1'b0;
            random_request();
        end
        i_s_tvalid <= 1'b0;

        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("graph_adjacency_store_top_tb: clean");
        end else begin
            $display("graph_adjacency_store_top_tb: errors");
        end
        $finish;
    end

endmodule
